/* rtl/rjd_pkg.sv */
// ----------------------------------------------------------------------------
// rjd_pkg - ramp jump detector shared definitions
// Result status codes, cause flag positions and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package rjd_pkg;

	typedef enum logic [1:0] {
		STATUS_NONE      = 2'd0,
		STATUS_BANG      = 2'd1,
		STATUS_SWALLOWED = 2'd2
	} status_t;

	// cause flag bit positions
	localparam int CAUSE_BACK    = 0;
	localparam int CAUSE_JUMP    = 1;
	localparam int CAUSE_RESTART = 2;
	localparam int CAUSE_COUNT   = 3;

	localparam int THRESH_WIDTH = 32;

	// register indexes
	localparam logic REG_THRESHOLD = 1'b0;
	localparam logic REG_WINDOW    = 1'b1;

	localparam logic [31:0] THRESHOLD_RESET  = 32'd256;
	localparam int          ECHO_TICKS_RESET = 99;

endpackage

`default_nettype wire

/* rtl/ramp_jump_detector_unit.sv */
// ----------------------------------------------------------------------------
// ramp_jump_detector_unit - discontinuity detector for a time-ramp stream
// Flags backward steps, delta jumps and restarts per vector, with an echo
// suppression window counted in tick transactions.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel (item_valid / item_stall): func = 0 carries a ramp sample,
//   func = 1 is a one millisecond tick. vector_last marks the end of a vector.
//   Result channel (result_valid / result_stall): one transaction per sample
//   with vector_last set, giving status and the causes seen in that vector.
//   Ticks and other samples produce no result.
//   APB port: register 0 at address 0 is the delta-change threshold,
//   register 1 at address 4 is echo_window_ticks. Write only while the
//   block is idle.
// Timing:
//   One item per cycle while item_stall is low. A vector-ending sample's
//   result is registered in the output register, or in the skid register
//   while a result is held: one subtract/compare stage computes state and result.
// Stall:
//   A two-entry output (output register plus skid register) lets one more
//   result in while a result is held; item_stall rises only while the skid
//   register is occupied, and results keep their order.
// Reset:
//   arst_n clears all tracking state, closes the echo window and restores
//   the delta-change threshold to 256 and echo_window_ticks to 99.
// ----------------------------------------------------------------------------
`default_nettype none

module ramp_jump_detector_unit #(
	parameter int SAMPLE_WIDTH = 32,
	parameter int WINDOW_WIDTH = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// item channel
	input  wire logic                           item_valid,
	output logic                                item_stall,
	input  wire logic                           func,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample_value,
	input  wire logic                           vector_last,
	// result channel
	output logic                                result_valid,
	input  wire logic                           result_stall,
	output rjd_pkg::status_t                    status,
	output logic                                went_backward,
	output logic                                jumped,
	output logic                                restarted,
	// configuration
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [2:0]                     paddr,
	input  wire logic [31:0]                    pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);
	import rjd_pkg::*;

	localparam int DW = SAMPLE_WIDTH + 1;   // sample difference
	localparam int EW = SAMPLE_WIDTH + 2;   // difference of deltas
	localparam int CW = (EW > THRESH_WIDTH) ? EW : THRESH_WIDTH;

	typedef struct packed {
		status_t                stat;
		logic [CAUSE_COUNT-1:0] causes;
	} result_t;

	// configuration registers
	logic [THRESH_WIDTH-1:0] threshold_q;
	logic [WINDOW_WIDTH-1:0] window_q;

	// tracking state
	logic signed [SAMPLE_WIDTH-1:0] prev_value_q, prev_value_n;
	logic signed [DW-1:0]           prev_delta_q, prev_delta_n;
	logic                           seeded_q, seeded_n;
	logic                           armed_q, armed_n;
	logic                           changed_q, changed_n;
	logic [CAUSE_COUNT-1:0]         causes_q, causes_n;
	logic                           echo_open_q, echo_open_n;
	logic [WINDOW_WIDTH-1:0]        echo_cnt_q, echo_cnt_n;

	// output register and skid
	logic    out_valid_q, skid_valid_q;
	result_t out_q, skid_q;
	logic    res_valid;
	result_t res;

	logic                 item_take, cfg_write, out_drain;
	logic signed [DW-1:0] delta;
	logic signed [EW-1:0] delta_diff;
	logic [EW-1:0]        mag;
	logic [CW-1:0]        mag_ext, thr_ext;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign item_take = item_valid && !item_stall;
	assign item_stall = skid_valid_q;

	always_comb begin
		case (paddr[2])
			REG_THRESHOLD: prdata = threshold_q;
			REG_WINDOW:    prdata = 32'(window_q);
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
			window_q    <= WINDOW_WIDTH'(ECHO_TICKS_RESET);
		end else if (cfg_write) begin
			case (paddr[2])
				REG_THRESHOLD: threshold_q <= pwdata;
				REG_WINDOW:    window_q    <= pwdata[WINDOW_WIDTH-1:0];
				default:       ;
			endcase
		end
	end

	// sample arithmetic, exact in widened signed values
	assign delta      = DW'(sample_value) - DW'(prev_value_q);
	assign delta_diff = EW'(delta) - EW'(prev_delta_q);
	assign mag        = delta_diff[EW-1] ? EW'(-delta_diff) : EW'(delta_diff);
	assign mag_ext    = CW'(mag);
	assign thr_ext    = CW'(threshold_q);

	always_comb begin
		prev_value_n = prev_value_q;
		prev_delta_n = prev_delta_q;
		seeded_n     = seeded_q;
		armed_n      = armed_q;
		changed_n    = changed_q;
		causes_n     = causes_q;
		echo_open_n  = echo_open_q;
		echo_cnt_n   = echo_cnt_q;
		res_valid    = 1'b0;
		res.stat     = STATUS_NONE;
		res.causes   = '0;
		if (item_take) begin
			if (func) begin
				// tick: run down the echo window
				if (echo_open_q) begin
					echo_cnt_n = echo_cnt_q - WINDOW_WIDTH'(1);
					if (echo_cnt_n == '0) echo_open_n = 1'b0;
				end
			end else begin
				if (!seeded_q) begin
					prev_value_n = sample_value;
					seeded_n     = 1'b1;
					changed_n    = 1'b1;
				end else begin
					if (sample_value != prev_value_q) begin
						if (delta[DW-1]) causes_n[CAUSE_BACK] = 1'b1;
						if (prev_delta_q != '0 && mag_ext > thr_ext)
							causes_n[CAUSE_JUMP] = 1'b1;
						if (armed_q) causes_n[CAUSE_RESTART] = 1'b1;
						armed_n      = 1'b0;
						prev_delta_n = delta;
						changed_n    = 1'b1;
					end
					prev_value_n = sample_value;
				end
				if (vector_last) begin
					// stationary vector arms the restart check
					if (seeded_n && !changed_n) begin
						armed_n      = 1'b1;
						prev_delta_n = '0;
					end
					res_valid  = 1'b1;
					res.causes = causes_n;
					if (causes_n != '0) begin
						if (echo_open_q) begin
							echo_open_n = 1'b0;
							echo_cnt_n  = '0;
							res.stat    = STATUS_SWALLOWED;
						end else begin
							res.stat    = STATUS_BANG;
							echo_cnt_n  = window_q;
							echo_open_n = (window_q != '0);
						end
					end
					causes_n  = '0;
					changed_n = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_value_q <= '0;
			prev_delta_q <= '0;
			seeded_q     <= 1'b0;
			armed_q      <= 1'b0;
			changed_q    <= 1'b0;
			causes_q     <= '0;
			echo_open_q  <= 1'b0;
			echo_cnt_q   <= '0;
		end else begin
			prev_value_q <= prev_value_n;
			prev_delta_q <= prev_delta_n;
			seeded_q     <= seeded_n;
			armed_q      <= armed_n;
			changed_q    <= changed_n;
			causes_q     <= causes_n;
			echo_open_q  <= echo_open_n;
			echo_cnt_q   <= echo_cnt_n;
		end
	end

	// output register with skid; item_stall holds new results off while skid is full
	assign out_drain = out_valid_q && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_drain) begin
			out_valid_q  <= skid_valid_q || res_valid;
			skid_valid_q <= 1'b0;
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_drain) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign result_valid  = out_valid_q;
	assign status        = out_q.stat;
	assign went_backward = out_q.causes[CAUSE_BACK];
	assign jumped        = out_q.causes[CAUSE_JUMP];
	assign restarted     = out_q.causes[CAUSE_RESTART];

endmodule

`default_nettype wire

/* rtl/rjd_checker.sv */
// ----------------------------------------------------------------------------
// rjd_port_props - port-level checks for the ramp jump detector
// Watches the result channel and the item stall over time.
// ----------------------------------------------------------------------------
`default_nettype none

module rjd_port_props (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             item_stall,
	input wire logic             result_valid,
	input wire logic             result_stall,
	input wire rjd_pkg::status_t status,
	input wire logic             went_backward,
	input wire logic             jumped,
	input wire logic             restarted
);
	import rjd_pkg::*;

	// held result transaction keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(status)
			&& $stable(went_backward) && $stable(jumped) && $stable(restarted))
		else $error("held result changed");

	// no detection means no cause
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == STATUS_NONE |-> !went_backward && !jumped && !restarted)
		else $error("cause reported without detection");

	// bang or swallow needs a cause
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != STATUS_NONE |-> went_backward || jumped || restarted)
		else $error("detection without cause");

	// input only backs up behind a held result
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && $past(result_valid && result_stall))
		else $error("item stall without held result");

endmodule

bind ramp_jump_detector_unit rjd_port_props u_rjd_port_props (
	.clk           (clk),
	.arst_n        (arst_n),
	.item_stall    (item_stall),
	.result_valid  (result_valid),
	.result_stall  (result_stall),
	.status        (status),
	.went_backward (went_backward),
	.jumped        (jumped),
	.restarted     (restarted)
);

`default_nettype wire

/* tb/sv/rjd_checker.sv */
// ----------------------------------------------------------------------------
// rjd_checker - result predictor and scoreboard for ramp_jump_detector_unit
// Watches the item, result and APB channels, keeps its own copy of the
// detector state and compares each result transaction against the oldest
// predicted vector report.
// ----------------------------------------------------------------------------
`default_nettype none

module rjd_checker (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	input  wire logic             item_stall,
	input  wire logic             func,
	input  wire logic [31:0]      sample_value,
	input  wire logic             vector_last,
	input  wire logic             result_valid,
	input  wire logic             result_stall,
	input  wire rjd_pkg::status_t status,
	input  wire logic             went_backward,
	input  wire logic             jumped,
	input  wire logic             restarted,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [2:0]       paddr,
	input  wire logic [31:0]      pwdata,
	input  wire logic             pready,
	output int                    errors,
	output int                    pending
);

	import rjd_pkg::*;

	localparam logic [2:0] ADDR_THRESHOLD = {REG_THRESHOLD, 2'b00};
	localparam logic [2:0] ADDR_WINDOW    = {REG_WINDOW, 2'b00};

	typedef struct {
		status_t status;
		logic    back;
		logic    jump;
		logic    restart;
	} vector_report_t;

	vector_report_t report_queue[$];

	// shadow of the registers and the tracking state
	logic [31:0]        thresh;
	logic [15:0]        win_len;
	logic signed [31:0] last_value;
	logic signed [32:0] prior_delta;
	logic               seeded;
	logic               armed;
	logic               moved;
	logic [2:0]         causes;
	logic               open;
	logic [15:0]        countdown;

	task automatic predict_item(input logic is_tick, input logic signed [31:0] val,
			input logic ends);
		longint         delta;
		longint         step_change;
		longint         mag;
		vector_report_t rep;
		if (is_tick) begin
			if (open) begin
				countdown = countdown - 16'd1;
				if (countdown == 16'd0)
					open = 1'b0;
			end
		end else begin
			if (!seeded) begin
				// first sample only seeds, and counts as a change
				seeded = 1'b1;
				moved  = 1'b1;
			end else if (val != last_value) begin
				delta       = longint'(val) - longint'(last_value);
				step_change = delta - longint'(prior_delta);
				mag         = (step_change < 0) ? -step_change : step_change;
				if (val < last_value)
					causes[CAUSE_BACK] = 1'b1;
				if (prior_delta != 0 && mag > longint'(thresh))
					causes[CAUSE_JUMP] = 1'b1;
				if (armed)
					causes[CAUSE_RESTART] = 1'b1;
				armed       = 1'b0;
				prior_delta = delta[32:0];
				moved       = 1'b1;
			end
			last_value = val;
			if (ends) begin
				if (seeded && !moved) begin
					armed       = 1'b1;
					prior_delta = '0;
				end
				rep.status = STATUS_NONE;
				if (causes != '0) begin
					if (open) begin
						// detection inside the echo window is swallowed
						open       = 1'b0;
						countdown  = '0;
						rep.status = STATUS_SWALLOWED;
					end else begin
						rep.status = STATUS_BANG;
						countdown  = win_len;
						open       = (win_len != 16'd0);
					end
				end
				rep.back    = causes[CAUSE_BACK];
				rep.jump    = causes[CAUSE_JUMP];
				rep.restart = causes[CAUSE_RESTART];
				report_queue.push_back(rep);
				causes = '0;
				moved  = 1'b0;
			end
		end
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : scoreboard
		vector_report_t rep;
		if (!arst_n) begin
			thresh      = THRESHOLD_RESET;
			win_len     = 16'(ECHO_TICKS_RESET);
			last_value  = '0;
			prior_delta = '0;
			seeded      = 1'b0;
			armed       = 1'b0;
			moved       = 1'b0;
			causes      = '0;
			open        = 1'b0;
			countdown   = '0;
			errors      = 0;
			report_queue.delete();
			pending     = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == ADDR_THRESHOLD)
					thresh = pwdata;
				else if (paddr == ADDR_WINDOW)
					win_len = pwdata[15:0];
			end
			if (result_valid && !result_stall) begin
				if (report_queue.size() == 0) begin
					$display("%0t: result transaction with none expected: status %0d flags %b%b%b",
						$time, status, went_backward, jumped, restarted);
					errors++;
				end else begin
					rep = report_queue.pop_front();
					check_field("status", rep.status, status);
					check_field("went_backward", rep.back, went_backward);
					check_field("jumped", rep.jump, jumped);
					check_field("restarted", rep.restart, restarted);
				end
			end
			if (item_valid && !item_stall)
				predict_item(func, sample_value, vector_last);
			pending = report_queue.size();
		end
	end

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top - testbench for ramp_jump_detector_unit
// Directed ramps hit the full-scale steps, threshold edges, stationary
// restarts and echo window cases, then random well-formed ramps with noise
// run under several register settings. Both channels idle at random; the
// checker predicts and scores every result transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	import rjd_pkg::*;

	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_TICK   = 1'b1;

	localparam logic [2:0] ADDR_THRESHOLD = {REG_THRESHOLD, 2'b00};
	localparam logic [2:0] ADDR_WINDOW    = {REG_WINDOW, 2'b00};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               item_valid;
	logic               item_stall;
	logic               func;
	logic signed [31:0] sample_value;
	logic               vector_last;
	logic               result_valid;
	logic               result_stall = 1'b0;
	status_t            status;
	logic               went_backward;
	logic               jumped;
	logic               restarted;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	int errors;
	int pending;

	// sender bookkeeping
	int unsigned tx_count = 0;
	bit          tx_burst = 1'b0;

	// receiver bookkeeping
	bit          rx_hold  = 1'b0;
	bit          rx_took  = 1'b0;
	bit          rx_burst = 1'b0;
	int unsigned rx_gap   = 0;

	// ramp generator state
	longint cur_value;
	longint cur_step;
	longint jit_span;

	always #5 clk = ~clk;

	ramp_jump_detector_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.func         (func),
		.sample_value (sample_value),
		.vector_last  (vector_last),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.went_backward(went_backward),
		.jumped       (jumped),
		.restarted    (restarted),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	rjd_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.func         (func),
		.sample_value (sample_value),
		.vector_last  (vector_last),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.went_backward(went_backward),
		.jumped       (jumped),
		.restarted    (restarted),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.errors       (errors),
		.pending      (pending)
	);

	// ------------------------------------------------------------------
	// Receiver: per result transaction, draw a random stall length.
	// rx_took flags an accepted transaction at the rising edge; the stall
	// decision is made at the falling edge that follows.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		rx_took <= result_valid && !result_stall;
	end

	always @(negedge clk) begin
		if (rx_hold) begin
			result_stall <= 1'b1;
		end else if (rx_took) begin
			// occasionally flip between gap-free and gappy stretches
			if ($urandom_range(29, 0) == 0)
				rx_burst = !rx_burst;
			rx_gap = rx_burst ? 0 : $urandom_range(19, 0);
			result_stall <= (rx_gap != 0);
			if (rx_gap != 0)
				rx_gap--;
		end else if (rx_gap != 0) begin
			result_stall <= 1'b1;
			rx_gap--;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// Long receiver hold-off while the sender keeps offering items, so the
	// output skid fills and item_stall must rise.
	initial begin : long_hold
		wait (tx_count >= 600);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (300) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// Run limit, far above the slowest legal run.
	initial begin : watchdog
		#4000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ------------------------------------------------------------------
	// Sender: one item transaction after a random idle gap.
	// Payload changes only at the falling edge and holds until accepted.
	// ------------------------------------------------------------------
	task automatic send_item(input logic f, input logic [31:0] v, input logic l);
		int unsigned gap;
		if ($urandom_range(39, 0) == 0)
			tx_burst = !tx_burst;
		gap = tx_burst ? 0 : $urandom_range(19, 0);
		@(negedge clk);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid   <= 1'b1;
		func         <= f;
		sample_value <= v;
		vector_last  <= l;
		do @(posedge clk); while (item_stall);
		tx_count++;
	endtask

	task automatic send_tick();
		// sample and vector_last are don't-care on a tick; drive noise
		send_item(FUNC_TICK, $urandom, 1'($urandom_range(1, 0)));
	endtask

	// Drop valid and wait until every predicted result has come out, then
	// let a trailing tick settle.
	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic configure(input logic [31:0] thr, input logic [15:0] win);
		drain();
		write_register(ADDR_THRESHOLD, thr);
		// upper bits of the window write are noise, the field is 16 bits
		write_register(ADDR_WINDOW, {16'($urandom), win});
		if (thr > 32'd4096)
			jit_span = 4096;
		else
			jit_span = longint'(thr) + 16;
	endtask

	// One vector of a mostly well-formed ramp: regular steps with jitter
	// around the threshold, plus stationary vectors, backward steps, jumps,
	// step changes, full-range noise and interleaved ticks.
	task automatic random_vector();
		int                 len;
		int                 i;
		int                 r;
		bit                 still;
		longint             mag;
		logic signed [31:0] wrapped;
		len   = ($urandom_range(3, 0) == 0) ? 1 : $urandom_range(8, 2);
		still = ($urandom_range(99, 0) < 15);
		// long tick run, sometimes long enough to let a default window expire
		if ($urandom_range(39, 0) == 0)
			repeat ($urandom_range(110, 20)) send_tick();
		for (i = 0; i < len; i++) begin
			if ($urandom_range(9, 0) < 3)
				repeat ($urandom_range(4, 1)) send_tick();
			r = $urandom_range(99, 0);
			if (still) begin
				// hold value for the whole vector
			end else if (r < 70) begin
				cur_value += cur_step + longint'($urandom_range(2 * jit_span, 0)) - jit_span;
			end else if (r < 78) begin
				// repeat of the last value inside a moving vector
			end else if (r < 85) begin
				cur_value -= longint'($urandom_range(5000, 1));
			end else if (r < 92) begin
				mag = longint'($urandom_range(1 << 20, 0)) + jit_span;
				cur_value += ($urandom_range(1, 0) != 0) ? mag : -mag;
			end else if (r < 96) begin
				cur_step = longint'($urandom_range(2048, 0));
				cur_value += cur_step;
			end else begin
				wrapped   = $urandom;
				cur_value = wrapped;
			end
			wrapped   = cur_value[31:0];
			cur_value = wrapped;
			send_item(FUNC_SAMPLE, wrapped, i == len - 1);
		end
	endtask

	initial begin : stimulus
		int          phase;
		int unsigned phase_end;
		logic [31:0] thr;
		logic [15:0] win;

		arst_n       <= 1'b0;
		item_valid   <= 1'b0;
		func         <= FUNC_SAMPLE;
		sample_value <= '0;
		vector_last  <= 1'b0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		cur_value    = 0;
		cur_step     = 256;
		jit_span     = 272;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// ---- directed part, reset settings (threshold 256, window 99) ----
		send_item(FUNC_SAMPLE, 32'h8000_0000, 1'b1); // seed at most negative value
		send_item(FUNC_SAMPLE, 32'h7FFF_FFFF, 1'b1); // full-scale forward step
		send_item(FUNC_SAMPLE, 32'h8000_0000, 1'b1); // backward and jump: bang
		send_tick();
		send_tick();
		send_item(FUNC_SAMPLE, 32'h8000_0000, 1'b1); // stationary vector arms restart
		send_item(FUNC_SAMPLE, 32'h8000_0100, 1'b0); // restart
		send_item(FUNC_SAMPLE, 32'h8000_0200, 1'b1); // detection in window: swallowed
		send_item(FUNC_SAMPLE, 32'h8000_0300, 1'b0); // same delta
		send_item(FUNC_SAMPLE, 32'h8000_0500, 1'b0); // delta change equals threshold
		send_item(FUNC_SAMPLE, 32'h8000_0801, 1'b1); // one past threshold: jump, bang
		repeat (3) send_tick();

		// zero threshold, zero-length window: a bang leaves the window shut
		configure(32'd0, 16'd0);
		send_item(FUNC_SAMPLE, 32'h8000_0901, 1'b1);
		send_item(FUNC_SAMPLE, 32'h8000_0A01, 1'b1);
		send_item(FUNC_SAMPLE, 32'h8000_0A00, 1'b1);

		// max threshold still trips on a full-scale reversal; window of one tick
		configure(32'hFFFF_FFFF, 16'd1);
		send_item(FUNC_SAMPLE, 32'h7FFF_FFFF, 1'b0);
		send_item(FUNC_SAMPLE, 32'h8000_0000, 1'b1);
		send_tick();
		send_item(FUNC_SAMPLE, 32'h7FFF_FFFF, 1'b1);
		send_item(FUNC_SAMPLE, 32'h7FFF_FFFF, 1'b1);
		send_tick();

		// ---- random part over several register settings ----
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					thr = THRESHOLD_RESET;
					win = 16'(ECHO_TICKS_RESET);
				end
				1: begin
					thr = 32'd0;
					win = 16'd0;
				end
				2: begin
					thr = 32'hFFFF_FFFF;
					win = 16'hFFFF;
				end
				3: begin
					thr = $urandom_range(2048, 0);
					win = 16'd1;
				end
				4: begin
					thr = $urandom;
					win = 16'($urandom_range(40, 2));
				end
				default: begin
					thr = $urandom_range(1024, 1);
					win = 16'($urandom_range(65535, 0));
				end
			endcase
			configure(thr, win);
			cur_step  = longint'($urandom_range(1024, 0));
			phase_end = tx_count + 300;
			while (tx_count < phase_end)
				random_vector();
		end

		drain();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire
